// ===== hw/rtl/epsc_pkg.sv =====
// Shared types, constants and helper functions for the encoder PI speed controller.
// No dependencies; used by epsc_ctrl, epsc_dp and encoder_pi_speed_controller.
`timescale 1ns / 1ps

package epsc_pkg;

    // Stream payload widths
    localparam int IN_DATA_W  = 32;   // encoder_count, target_speed
    localparam int OUT_DATA_W = 56;   // pwm_compare, direction_cw, measured_speed, pad

    // Config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_COEF    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_DIVISOR  = 3'd4;

    localparam logic [15:0] RST_PWM_PERIOD    = 16'd65535;
    localparam logic [19:0] RST_SPEED_COEF    = 20'd107233;
    localparam logic [7:0]  RST_PROP_GAIN     = 8'd3;
    localparam logic [23:0] RST_INTEGRAL_GAIN = 24'd39322;
    localparam logic [7:0]  RST_DUTY_DIVISOR  = 8'd13;

    // Item kinds on tuser
    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_TARGET = 1'b1;

    // Datapath widths
    localparam int ERR_W   = 33;             // target - speed, negated when w_neg is set in epsc_dp
    localparam int MA_W    = 33;             // multiplier operand A (signed)
    localparam int MB_W    = 25;             // multiplier operand B (signed)
    localparam int PROD_W  = MA_W + MB_W;    // full product
    localparam int QUO_W   = PROD_W - 16;    // product / 2^16
    localparam int SUM_W   = QUO_W + 1;      // accumulate before saturation
    localparam int FRAC_W  = 8;              // duty numerator, 0..divisor

    // Compare divider: 16 quotient bits, two per cycle
    localparam int DIV_Q_W       = 16;
    localparam int DIV_BITS_STEP = 2;
    localparam int DIV_STEPS     = DIV_Q_W / DIV_BITS_STEP;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [15:0] pwm_period;
        logic [19:0] speed_coef;
        logic [7:0]  prop_gain;
        logic [23:0] integral_gain;
        logic [7:0]  duty_divisor;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TGT,
        S_MUL_SPD,
        S_SPD,
        S_ERR,
        S_MUL_INT,
        S_INT,
        S_FRAC,
        S_MUL_SCL,
        S_DIV_LD,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_SPEED,
        MUL_INTEG,
        MUL_PROP,
        MUL_SCALE
    } t_mul_sel;

    typedef struct packed {
        logic     load;       // latch input item
        logic     mul_en;     // register multiplier product
        t_mul_sel mul_sel;
        logic     last_en;    // update last encoder count
        logic     speed_en;
        logic     err_en;
        logic     integ_en;
        logic     frac_en;
        logic     div_start;
        logic     div_step;
        logic     tgt_en;
        logic     out_load;   // push result into output register
    } t_cmd;

    typedef struct packed {
        logic div_last;       // final divider step this cycle
        logic out_free;       // output register can take a result
    } t_sts;

    // Drop 16 fraction bits, rounding toward zero
    function automatic logic signed [QUO_W-1:0] trunc_q16(input logic signed [PROD_W-1:0] p);
        logic signed [QUO_W-1:0] q;
        logic                    adj;
        q   = p[PROD_W-1:16];
        adj = p[PROD_W-1] & (|p[15:0]);
        return q + QUO_W'(adj);
    endfunction

    // Saturate to 32-bit signed
    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if (!v[SUM_W-1] && (|v[SUM_W-2:31])) begin
            r = 32'sh7FFF_FFFF;
        end else if (v[SUM_W-1] && !(&v[SUM_W-2:31])) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/encoder_pi_speed_controller.sv =====
// Top level of the encoder PI speed controller: stream ports, config registers,
// result register. Depends on epsc_pkg, epsc_ctrl and epsc_dp.
`timescale 1ns / 1ps

// One motor channel. Each input item is either a control tick (tuser = 0) carrying the
// low bits of the quadrature position counter, or a new speed target (tuser = 1). A tick
// turns the wrapped count delta into a speed, runs the PI law and emits a PWM compare
// value; a target item changes direction and, if the target really changed, clears the
// integral. Every item gives exactly one result: compare, direction and last speed.
// Items are handled one at a time. A tick walks through eight sequencer steps around
// one shared 33x25 multiplier, then the compare divider (two quotient bits per cycle),
// then the result load. A target item passes through S_TGT and then the result load.
// A finished result sits in the output register, so the next item is accepted while
// it waits; the result load only stalls when that register is still full. Config
// registers are written through the cfg channel (always ready) and must only change
// while the block is idle.

module encoder_pi_speed_controller #(
    parameter int COUNT_BITS = 16     // width of the encoder counter, 8..16 (the port carries 16 count bits)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [epsc_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [15:0] encoder_count,
                                                                // [31:16] target_speed
    input  logic                                s_axis_tuser,   // [0] kind
    // result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [epsc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // [15:0] pwm_compare,
                                                                // [16] direction_cw,
                                                                // [48:17] measured_speed,
                                                                // [55:49] zero
    // config writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [epsc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [epsc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    epsc_pkg::t_cfg  r_cfg;
    epsc_pkg::t_cmd  w_cmd;
    epsc_pkg::t_sts  w_sts;

    logic                                   r_out_valid;
    logic [epsc_pkg::OUT_DATA_W-1:0]        r_out_data;

    logic                                   w_div_last;
    logic [15:0]                            w_compare;
    logic                                   w_dir;
    logic signed [31:0]                     w_speed;
    logic                                   w_in_ready;

    // config registers; writes land at once
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pwm_period    <= epsc_pkg::RST_PWM_PERIOD;
            r_cfg.speed_coef    <= epsc_pkg::RST_SPEED_COEF;
            r_cfg.prop_gain     <= epsc_pkg::RST_PROP_GAIN;
            r_cfg.integral_gain <= epsc_pkg::RST_INTEGRAL_GAIN;
            r_cfg.duty_divisor  <= epsc_pkg::RST_DUTY_DIVISOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                epsc_pkg::CFG_PWM_PERIOD:    r_cfg.pwm_period    <= i_cfg_data[15:0];
                epsc_pkg::CFG_SPEED_COEF:    r_cfg.speed_coef    <= i_cfg_data[19:0];
                epsc_pkg::CFG_PROP_GAIN:     r_cfg.prop_gain     <= i_cfg_data[7:0];
                epsc_pkg::CFG_INTEGRAL_GAIN: r_cfg.integral_gain <= i_cfg_data[23:0];
                epsc_pkg::CFG_DUTY_DIVISOR:  r_cfg.duty_divisor  <= i_cfg_data[7:0];
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // status toward the sequencer
    assign w_sts.div_last = w_div_last;
    assign w_sts.out_free = !r_out_valid || m_axis_tready;

    epsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    epsc_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_cmd),
        .i_in_count  (s_axis_tdata[15:0]),
        .i_in_target ($signed(s_axis_tdata[31:16])),
        .o_div_last  (w_div_last),
        .o_compare   (w_compare),
        .o_dir       (w_dir),
        .o_speed     (w_speed)
    );

    assign s_axis_tready = w_in_ready;

    // output register: loaded by the sequencer, drained by the sink
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_out_data <= {7'd0, w_speed, w_dir, w_compare};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_one_item_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted while one is in work");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!r_out_valid || m_axis_tready))
        else $error("result register overwritten before it was taken");
`endif

endmodule

// ===== hw/rtl/epsc_ctrl.sv =====
// Sequencer for the encoder PI speed controller: walks one item through the datapath.
// Depends on epsc_pkg (state, command and status types).
`timescale 1ns / 1ps

module epsc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_kind,
    output logic             o_in_ready,
    input  epsc_pkg::t_sts   i_sts,
    output epsc_pkg::t_cmd   o_cmd
);

    epsc_pkg::t_state r_state;
    epsc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= epsc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.mul_sel = epsc_pkg::MUL_SPEED;
        unique case (r_state)
            epsc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_in_kind == epsc_pkg::KIND_TARGET) ?
                                 epsc_pkg::S_TGT : epsc_pkg::S_MUL_SPD;
                end
            end
            epsc_pkg::S_TGT: begin
                o_cmd.tgt_en = 1'b1;
                n_state      = epsc_pkg::S_DONE;
            end
            epsc_pkg::S_MUL_SPD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = epsc_pkg::MUL_SPEED;
                o_cmd.last_en = 1'b1;
                n_state       = epsc_pkg::S_SPD;
            end
            epsc_pkg::S_SPD: begin
                o_cmd.speed_en = 1'b1;
                n_state        = epsc_pkg::S_ERR;
            end
            epsc_pkg::S_ERR: begin
                o_cmd.err_en = 1'b1;
                n_state      = epsc_pkg::S_MUL_INT;
            end
            epsc_pkg::S_MUL_INT: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = epsc_pkg::MUL_INTEG;
                n_state       = epsc_pkg::S_INT;
            end
            epsc_pkg::S_INT: begin
                // integral reads the old product while kp*err is captured
                o_cmd.integ_en = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = epsc_pkg::MUL_PROP;
                n_state        = epsc_pkg::S_FRAC;
            end
            epsc_pkg::S_FRAC: begin
                o_cmd.frac_en = 1'b1;
                n_state       = epsc_pkg::S_MUL_SCL;
            end
            epsc_pkg::S_MUL_SCL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = epsc_pkg::MUL_SCALE;
                n_state       = epsc_pkg::S_DIV_LD;
            end
            epsc_pkg::S_DIV_LD: begin
                o_cmd.div_start = 1'b1;
                n_state         = epsc_pkg::S_DIV;
            end
            epsc_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = epsc_pkg::S_DONE;
                end
            end
            epsc_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = epsc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = epsc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/epsc_dp.sv =====
// Datapath of the encoder PI speed controller: state registers, shared multiplier,
// PI arithmetic and a two-bit-per-cycle compare divider. Depends on epsc_pkg.
`timescale 1ns / 1ps

module epsc_dp #(
    parameter int COUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  epsc_pkg::t_cfg      i_cfg,
    input  epsc_pkg::t_cmd      i_cmd,
    input  logic [15:0]         i_in_count,
    input  logic signed [15:0]  i_in_target,
    output logic                o_div_last,
    output logic [15:0]         o_compare,
    output logic                o_dir,
    output logic signed [31:0]  o_speed
);

    // latched item
    logic [15:0]                          r_in_count;
    logic signed [15:0]                   r_in_target;

    // controller state
    logic [COUNT_BITS-1:0]                r_last;
    logic signed [15:0]                   r_target;
    logic                                 r_dir;
    logic signed [31:0]                   r_integ;
    logic signed [31:0]                   r_speed;
    logic [15:0]                          r_compare;

    // working registers
    logic signed [epsc_pkg::ERR_W-1:0]    r_err;
    logic signed [epsc_pkg::PROD_W-1:0]   r_prod;
    logic [epsc_pkg::FRAC_W-1:0]          r_frac;
    logic [7:0]                           r_rem;
    logic [epsc_pkg::DIV_Q_W-1:0]         r_q;
    logic [epsc_pkg::DIV_CNT_W-1:0]       r_div_cnt;

    logic [COUNT_BITS-1:0]                w_cnt;
    logic signed [COUNT_BITS-1:0]         w_delta;
    logic signed [epsc_pkg::MA_W-1:0]     w_ma;
    logic signed [epsc_pkg::MB_W-1:0]     w_mb;
    logic signed [epsc_pkg::PROD_W-1:0]   w_prod;
    logic signed [epsc_pkg::QUO_W-1:0]    w_quo;
    logic signed [31:0]                   n_speed;
    logic signed [31:0]                   n_integ;
    logic signed [epsc_pkg::ERR_W-1:0]    w_diff;
    logic                                 w_neg;
    logic signed [epsc_pkg::ERR_W-1:0]    n_err;
    logic [7:0]                           w_div;
    logic signed [epsc_pkg::PROD_W-1:0]   w_num;
    logic signed [epsc_pkg::PROD_W-1:0]   w_div_ext;
    logic [epsc_pkg::FRAC_W-1:0]          w_numc;
    logic [epsc_pkg::FRAC_W-1:0]          n_frac;
    logic [7:0]                           n_rem;
    logic [epsc_pkg::DIV_Q_W-1:0]         n_q;
    logic [8:0]                           w_rem2;
    logic                                 w_tgt_new;

    // wrap-aware count delta
    assign w_cnt   = COUNT_BITS'(r_in_count);
    assign w_delta = $signed(w_cnt - r_last);

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.mul_sel)
            epsc_pkg::MUL_SPEED: begin
                w_ma = epsc_pkg::MA_W'(w_delta);
                w_mb = $signed(epsc_pkg::MB_W'(i_cfg.speed_coef));
            end
            epsc_pkg::MUL_INTEG: begin
                w_ma = r_err;
                w_mb = $signed(epsc_pkg::MB_W'(i_cfg.integral_gain));
            end
            epsc_pkg::MUL_PROP: begin
                w_ma = r_err;
                w_mb = $signed(epsc_pkg::MB_W'(i_cfg.prop_gain));
            end
            epsc_pkg::MUL_SCALE: begin
                w_ma = $signed(epsc_pkg::MA_W'(i_cfg.pwm_period));
                w_mb = $signed(epsc_pkg::MB_W'(r_frac));
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // speed and integral both take the product rounded toward zero
    assign w_quo   = epsc_pkg::trunc_q16(r_prod);
    assign n_speed = epsc_pkg::sat32(epsc_pkg::SUM_W'(w_quo));
    assign n_integ = epsc_pkg::sat32(epsc_pkg::SUM_W'(r_integ) + epsc_pkg::SUM_W'(w_quo));

    // error, sign follows the target direction
    assign w_diff = epsc_pkg::ERR_W'(r_target) - epsc_pkg::ERR_W'(r_speed);
    assign w_neg  = r_target[15] || ((r_target == 16'sd0) && r_speed[31]);
    assign n_err  = w_neg ? -w_diff : w_diff;

    // duty numerator, clamped to 0..divisor
    assign w_div     = (i_cfg.duty_divisor == 8'd0) ? 8'd1 : i_cfg.duty_divisor;
    assign w_num     = r_prod + epsc_pkg::PROD_W'(r_integ);
    assign w_div_ext = $signed(epsc_pkg::PROD_W'(w_div));

    always_comb begin
        if (w_num[epsc_pkg::PROD_W-1]) begin
            w_numc = '0;
        end else if (w_num > w_div_ext) begin
            w_numc = w_div;
        end else begin
            w_numc = w_num[epsc_pkg::FRAC_W-1:0];
        end
    end

    assign n_frac = r_dir ? w_numc : (w_div - w_numc);

    // restoring divider, dividend bits shift out of r_q as quotient bits shift in
    always_comb begin
        n_rem  = r_rem;
        n_q    = r_q;
        w_rem2 = '0;
        for (int k = 0; k < epsc_pkg::DIV_BITS_STEP; k++) begin
            w_rem2 = {n_rem, n_q[epsc_pkg::DIV_Q_W-1]};
            n_q    = {n_q[epsc_pkg::DIV_Q_W-2:0], 1'b0};
            if (w_rem2 >= {1'b0, w_div}) begin
                w_rem2 = w_rem2 - {1'b0, w_div};
                n_q[0] = 1'b1;
            end
            n_rem = w_rem2[7:0];
        end
    end

    assign o_div_last = (r_div_cnt == epsc_pkg::DIV_CNT_W'(epsc_pkg::DIV_STEPS - 1));
    assign w_tgt_new  = (r_in_target != r_target);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '0;
            r_target  <= '0;
            r_dir     <= 1'b0;
            r_integ   <= '0;
            r_speed   <= '0;
            r_compare <= '0;
            r_div_cnt <= '0;
        end else begin
            if (i_cmd.last_en) begin
                r_last <= w_cnt;
            end
            if (i_cmd.speed_en) begin
                r_speed <= n_speed;
            end
            if (i_cmd.integ_en) begin
                r_integ <= n_integ;
            end
            if (i_cmd.tgt_en && w_tgt_new) begin
                r_target <= r_in_target;
                r_dir    <= !r_in_target[15] && (r_in_target != 16'sd0);
                r_integ  <= '0;
            end
            if (i_cmd.div_start) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
                if (o_div_last) begin
                    r_compare <= n_q;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_count  <= i_in_count;
            r_in_target <= i_in_target;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.err_en) begin
            r_err <= n_err;
        end
        if (i_cmd.frac_en) begin
            r_frac <= n_frac;
        end
        if (i_cmd.div_start) begin
            r_rem <= r_prod[23:16];
            r_q   <= r_prod[15:0];
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_compare = r_compare;
    assign o_dir     = r_dir;
    assign o_speed   = r_speed;

`ifndef SYNTHESIS
    a_dir_tracks_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dir == (!r_target[15] && (r_target != 16'sd0)))
        else $error("direction bit disagrees with target sign");

    a_new_target_clears_integral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tgt_en && (r_in_target != r_target))
        |=> ((r_integ == 32'sd0) && (r_target == $past(r_in_target))))
        else $error("new target did not reset integral");
`endif

endmodule
